// ===== hw/rtl/rstk_pkg.sv =====
// Shared types and constants of the record stack with key search.
package rstk_pkg;

  localparam int unsigned DEPTH   = 128;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

  localparam int unsigned NAME_W  = 64;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned IDX_W   = 7;
  localparam int unsigned COUNT_W = 8;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SRCH,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [NAME_W-1:0] first_name;
    logic [NAME_W-1:0] last_name;
    logic [YEAR_W-1:0] birth_year;
  } rec_t;

  typedef struct packed {
    status_e           status;
    rec_t              rec;
    logic [ADDR_W-1:0] idx;
  } res_t;

  localparam rec_t REC_ZERO = '0;

endpackage

// ===== hw/rtl/rstk_if.sv =====
// Handshake channels of the record stack: request and response.
interface rstk_req_if
  import rstk_pkg::*;
;
  logic                  valid;
  logic                  ready;
  action_e               action;
  logic [NAME_W-1:0]     first_name;
  logic [NAME_W-1:0]     last_name;
  logic [YEAR_W-1:0]     birth_year;

  modport source (output valid, action, first_name, last_name, birth_year, input ready);
  modport sink   (input valid, action, first_name, last_name, birth_year, output ready);
endinterface

interface rstk_rsp_if
  import rstk_pkg::*;
;
  logic                  valid;
  logic                  ready;
  status_e               status;
  logic [NAME_W-1:0]     out_first_name;
  logic [NAME_W-1:0]     out_last_name;
  logic [YEAR_W-1:0]     out_birth_year;
  logic [IDX_W-1:0]      found_index;
  logic [COUNT_W-1:0]    entry_count;

  modport source (output valid, status, out_first_name, out_last_name, out_birth_year,
                  found_index, entry_count, input ready);
  modport sink   (input valid, status, out_first_name, out_last_name, out_birth_year,
                  found_index, entry_count, output ready);
endinterface

// ===== hw/rtl/record_stack_with_key_search_top.sv =====
// Record stack with surname search: top level.
//
// Bounded LIFO of DEPTH records (first name, surname, birth year) kept in one
// synchronous single-port-read memory. One request is handled at a time. Push,
// clear and the empty-stack cases of pop and search go from acceptance straight
// to the emit state. A pop that reads a record first passes the pop state, where
// the memory read returns. A search reads one entry per cycle from the top down,
// and the memory read port sets that rate; it goes to the emit state at the first
// hit, or with a miss once the bottom entry has been compared. The emit state
// waits until the output register is free and then loads it. The result is held
// in an output register, so a new request is accepted while the previous result
// waits. The stored records have no reset; only entries below the fill level are
// read.
module record_stack_with_key_search_top
  import rstk_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  rstk_req_if.sink   in_i,
  rstk_rsp_if.source out_o
);

  // record memory
  rec_t              mem_q [DEPTH];
  rec_t              rd_data_q;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  rec_t              wr_data;

  // control and work registers
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  cnt_m1;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [NAME_W-1:0] key_q, key_d;
  res_t              res_q, res_d;
  logic              emit;

  // output register
  logic              out_valid_q;
  res_t              out_q;
  logic [CNT_W-1:0]  out_cnt_q;

  assign cnt_m1 = cnt_q - CNT_W'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    key_d     = key_q;
    res_d     = res_q;
    emit      = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = cnt_q[ADDR_W-1:0];
    wr_data   = '{first_name: in_i.first_name, last_name: in_i.last_name,
                  birth_year: in_i.birth_year};
    rd_en     = 1'b0;
    rd_addr   = cnt_m1[ADDR_W-1:0];
    in_i.ready = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          res_d   = '{status: ST_OK, rec: REC_ZERO, idx: '0};
          state_d = S_EMIT;
          unique case (in_i.action)
            ACT_PUSH: begin
              if (cnt_q == CNT_W'(DEPTH)) begin
                res_d.status = ST_FULL;
              end else begin
                wr_en = 1'b1;
                cnt_d = cnt_q + CNT_W'(1);
              end
            end
            ACT_POP: begin
              if (cnt_q == '0) begin
                res_d.status = ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                cnt_d   = cnt_m1;
                state_d = S_POP;
              end
            end
            ACT_SEARCH: begin
              if (cnt_q == '0) begin
                res_d.status = ST_NOT_FOUND;
              end else begin
                rd_en   = 1'b1;
                idx_d   = cnt_m1[ADDR_W-1:0];
                key_d   = in_i.last_name;
                state_d = S_SRCH;
              end
            end
            ACT_CLEAR: begin
              cnt_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        res_d   = '{status: ST_OK, rec: rd_data_q, idx: '0};
        state_d = S_EMIT;
      end
      S_SRCH: begin
        // rd_data_q holds the entry at idx_q
        if (rd_data_q.last_name == key_q) begin
          res_d   = '{status: ST_OK, rec: rd_data_q, idx: idx_q};
          state_d = S_EMIT;
        end else if (idx_q == '0) begin
          res_d   = '{status: ST_NOT_FOUND, rec: REC_ZERO, idx: '0};
          state_d = S_EMIT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_q - ADDR_W'(1);
          idx_d   = idx_q - ADDR_W'(1);
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    key_q <= key_d;
    res_q <= res_d;
    if (emit) begin
      out_q     <= res_q;
      out_cnt_q <= cnt_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_q.status;
  assign out_o.out_first_name = out_q.rec.first_name;
  assign out_o.out_last_name  = out_q.rec.last_name;
  assign out_o.out_birth_year = out_q.rec.birth_year;
  assign out_o.found_index    = IDX_W'(out_q.idx);
  assign out_o.entry_count    = COUNT_W'(out_cnt_q);

endmodule

// ===== tb/tb_record_stack_with_key_search_top.sv =====
// Testbench of the record stack: random push/pop/search/clear traffic, checked against a predictor.
package rstk_tb_pkg;
  import rstk_pkg::*;

  typedef struct {
    status_e             status;
    logic [NAME_W-1:0]   first_name;
    logic [NAME_W-1:0]   last_name;
    logic [YEAR_W-1:0]   birth_year;
    logic [IDX_W-1:0]    found_index;
    logic [COUNT_W-1:0]  entry_count;
  } stack_reply_t;

  class record_stack_checker;
    logic [NAME_W-1:0] first_mem [DEPTH];
    logic [NAME_W-1:0] last_mem  [DEPTH];
    logic [YEAR_W-1:0] year_mem  [DEPTH];
    int unsigned       level;
    stack_reply_t      expected_replies [$];
    int unsigned       failures;

    function new();
      level    = 0;
      failures = 0;
    endfunction

    function int unsigned held();
      return level;
    endfunction

    function logic [NAME_W-1:0] surname_at(int unsigned pos);
      return last_mem[pos];
    endfunction

    function int unsigned outstanding();
      return expected_replies.size();
    endfunction

    // Predict the reply of one accepted request and queue it.
    function void note_request(action_e act, logic [NAME_W-1:0] fn,
                               logic [NAME_W-1:0] ln, logic [YEAR_W-1:0] yr);
      stack_reply_t r;
      int           pos;
      r = '{ST_OK, '0, '0, '0, '0, '0};
      case (act)
        ACT_PUSH: begin
          if (level >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            first_mem[level] = fn;
            last_mem[level]  = ln;
            year_mem[level]  = yr;
            level++;
          end
        end
        ACT_POP: begin
          if (level == 0) begin
            r.status = ST_EMPTY;
          end else begin
            level--;
            r.first_name = first_mem[level];
            r.last_name  = last_mem[level];
            r.birth_year = year_mem[level];
          end
        end
        ACT_SEARCH: begin
          r.status = ST_NOT_FOUND;
          // top-down: the most recent match wins
          for (pos = int'(level) - 1; pos >= 0; pos--) begin
            if (last_mem[pos] == ln) begin
              r.status      = ST_OK;
              r.first_name  = first_mem[pos];
              r.last_name   = last_mem[pos];
              r.birth_year  = year_mem[pos];
              r.found_index = IDX_W'(pos);
              break;
            end
          end
        end
        default: begin
          level = 0;
        end
      endcase
      r.entry_count = COUNT_W'(level);
      expected_replies.push_back(r);
    endfunction

    function void check_reply(stack_reply_t got);
      stack_reply_t want;
      if (expected_replies.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("reply with nothing outstanding: st=%0d fn=%h ln=%h yr=%0d idx=%0d cnt=%0d",
                   got.status, got.first_name, got.last_name, got.birth_year,
                   got.found_index, got.entry_count);
        return;
      end
      want = expected_replies.pop_front();
      if (got.status !== want.status || got.first_name !== want.first_name ||
          got.last_name !== want.last_name || got.birth_year !== want.birth_year ||
          got.found_index !== want.found_index || got.entry_count !== want.entry_count) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch exp: st=%0d fn=%h ln=%h yr=%0d idx=%0d cnt=%0d",
                   want.status, want.first_name, want.last_name, want.birth_year,
                   want.found_index, want.entry_count);
          $display("         got: st=%0d fn=%h ln=%h yr=%0d idx=%0d cnt=%0d",
                   got.status, got.first_name, got.last_name, got.birth_year,
                   got.found_index, got.entry_count);
        end
      end
    endfunction
  endclass

endpackage

module tb_record_stack_with_key_search_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rstk_pkg::*;
  import rstk_tb_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = DEPTH + 8;
  localparam int unsigned IDLE_PCT     = 37;

  logic clk_i;
  logic rst_ni;

  rstk_req_if req_if ();
  rstk_rsp_if rsp_if ();

  record_stack_with_key_search_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  record_stack_checker checker_h = new();

  int unsigned       items_sent;
  bit                idling_off;
  logic [NAME_W-1:0] surname_pool [8];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [NAME_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [YEAR_W-1:0] rand_year();
    if ($urandom_range(0, 3) == 0) return YEAR_W'($urandom);
    return YEAR_W'($urandom_range(0, 9999));
  endfunction

  function automatic logic [NAME_W-1:0] pick_surname();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5 && checker_h.held() > 0)
      return checker_h.surname_at($urandom_range(0, checker_h.held() - 1));
    if (sel < 8) return surname_pool[$urandom_range(0, 7)];
    return rand_key();
  endfunction

  task automatic send(action_e act, logic [NAME_W-1:0] fn, logic [NAME_W-1:0] ln,
                      logic [YEAR_W-1:0] yr);
    idling_off = (items_sent >= 300 && items_sent < 420);
    while (!idling_off && $urandom_range(0, 99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.action     <= act;
    req_if.first_name <= fn;
    req_if.last_name  <= ln;
    req_if.birth_year <= yr;
    do @(posedge clk_i); while (!req_if.ready);
    checker_h.note_request(act, fn, ln, yr);
    items_sent++;
  endtask

  task automatic push_rec(logic [NAME_W-1:0] ln);
    send(ACT_PUSH, rand_key(), ln, rand_year());
  endtask

  // Fill to the top, bounce off it, search the deepest and highest slots' surnames and a random one, pop, push.
  task automatic fill_stack();
    logic [NAME_W-1:0] top_key;
    logic [NAME_W-1:0] bottom_key;
    while (checker_h.held() < DEPTH)
      push_rec(($urandom_range(0, 1) == 0) ? surname_pool[$urandom_range(0, 7)] : rand_key());
    repeat ($urandom_range(1, 3)) push_rec(rand_key());
    top_key    = checker_h.surname_at(DEPTH - 1);
    bottom_key = checker_h.surname_at(0);
    send(ACT_SEARCH, rand_key(), top_key, rand_year());
    send(ACT_SEARCH, rand_key(), bottom_key, rand_year());
    send(ACT_SEARCH, rand_key(), rand_key(), rand_year());
    send(ACT_POP, '0, '0, '0);
    push_rec(rand_key());
  endtask

  // Response side: check every transaction, stall at random.
  initial begin
    stack_reply_t got;
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.status      = rsp_if.status;
        got.first_name  = rsp_if.out_first_name;
        got.last_name   = rsp_if.out_last_name;
        got.birth_year  = rsp_if.out_birth_year;
        got.found_index = rsp_if.found_index;
        got.entry_count = rsp_if.entry_count;
        checker_h.check_reply(got);
      end
      rsp_if.ready <= (!rst_ni || (!idling_off && $urandom_range(0, 99) < IDLE_PCT)) ? 1'b0 : 1'b1;
      @(posedge clk_i);
    end
  end

  // Watchdog: cycles without any transaction on either side.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || !rst_ni)
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [NAME_W-1:0] dup_key;
    int unsigned       sel;
    int unsigned       fills;
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.action     <= ACT_PUSH;
    req_if.first_name <= '0;
    req_if.last_name  <= '0;
    req_if.birth_year <= '0;
    items_sent = 0;
    idling_off = 1'b0;
    fills      = 0;
    foreach (surname_pool[k]) surname_pool[k] = rand_key();
    dup_key = surname_pool[0];
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty-stack corners, field extremes, duplicate surnames, clear
    send(ACT_POP,    '0, '0, '0);
    send(ACT_SEARCH, '1, '1, '1);
    send(ACT_CLEAR,  '0, '0, '0);
    send(ACT_PUSH,   '0, '0, '0);
    send(ACT_PUSH,   '1, '1, '1);
    send(ACT_PUSH,   rand_key(), dup_key, YEAR_W'(9999));
    send(ACT_PUSH,   rand_key(), dup_key, YEAR_W'(1));
    send(ACT_SEARCH, '0, dup_key, '0);
    send(ACT_SEARCH, '1, '0, '1);
    send(ACT_SEARCH, '0, '1, '0);
    send(ACT_SEARCH, '0, rand_key(), '0);
    send(ACT_POP,    '0, '0, '0);
    send(ACT_SEARCH, '0, dup_key, '0);
    send(ACT_POP,    '1, '1, '1);
    send(ACT_POP,    '0, '0, '0);
    send(ACT_POP,    '0, '0, '0);
    send(ACT_POP,    '0, '0, '0);
    send(ACT_PUSH,   rand_key(), rand_key(), YEAR_W'(16383));
    send(ACT_CLEAR,  '1, '1, '1);
    send(ACT_SEARCH, '0, '0, '0);
    send(ACT_POP,    '0, '0, '0);

    while (items_sent < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 36) begin
        repeat ($urandom_range(1, 12)) push_rec(pick_surname());
      end else if (sel < 54) begin
        repeat ($urandom_range(1, 8)) send(ACT_POP, rand_key(), rand_key(), rand_year());
      end else if (sel < 82) begin
        repeat ($urandom_range(1, 4)) send(ACT_SEARCH, rand_key(), pick_surname(), rand_year());
      end else if (sel < 86) begin
        send(ACT_CLEAR, rand_key(), rand_key(), rand_year());
      end else if (sel < 90 && fills < 2 && items_sent > 100) begin
        fill_stack();
        fills++;
      end else begin
        send(action_e'($urandom_range(0, 3)), rand_key(), rand_key(), YEAR_W'($urandom));
      end
    end
    req_if.valid <= 1'b0;

    while (checker_h.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (checker_h.failures == 0 && checker_h.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
